### src/cross_neighbour_mean_filter_defines.svh
// Assertion macros for the cross neighbour mean filter.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef CROSS_NEIGHBOUR_MEAN_FILTER_DEFINES_SVH
`define CROSS_NEIGHBOUR_MEAN_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CNMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cnmf_pkg.sv
// Shared constants, types and functions of the cross neighbour mean filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cnmf_pkg;

  // Default frame limits, handed to the top-level parameters
  localparam int MaxWidthDef  = 128;
  localparam int MaxHeightDef = 4096;

  // Field widths of the stream and configuration ports
  localparam int PixW     = 8;
  localparam int RowOutW  = 12;
  localparam int ColOutW  = 7;
  localparam int MeanW    = 16;
  localparam int DataOutW = 40;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int FwCfgW   = 8;
  localparam int FhCfgW   = 13;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 8'd1;

  // Reset frame size before clamping
  localparam int DimReset = 5;

  // Arithmetic of the mean: sum of up to five pixels, count of 1..5
  localparam int SumW      = 11;
  localparam int CntW      = 3;
  localparam int RecipW    = 22;
  localparam int MeanShift = 21;

  // Depth of the queue between front and back
  localparam int QDepth = 4;

  // Position class of one pixel, worked out by the front
  typedef struct packed {
    logic up1;       // row >= 1
    logic up2;       // row >= 2
    logic left1;     // col >= 1
    logic left2;     // col >= 2
    logic right;     // col + 1 < width
    logic last_row;
    logic last_col;
  } item_flags_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ceil(2^21 / n); exact floor division for every dividend below 2^19
  function automatic logic [RecipW-1:0] mean_recip(input logic [CntW-1:0] n);
    case (n)
      3'd1:    return 22'd2097152;
      3'd2:    return 22'd1048576;
      3'd3:    return 22'd699051;
      3'd4:    return 22'd524288;
      3'd5:    return 22'd419431;
      default: return '0;
    endcase
  endfunction

endpackage

### src/cnmf_queue.sv
// Small FIFO between the front and the back of the filter.
// Depends on cnmf_pkg for the status struct.
`timescale 1ns / 1ps

module cnmf_queue
  import cnmf_pkg::*;
#(
  parameter int DW    = 8,
  parameter int DEPTH = QDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output q_stat_t       stat_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = buf_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == NW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

### src/cnmf_front.sv
// Front of the filter: configuration registers, frame position tracking and
// classification of each accepted pixel. Depends on cnmf_pkg.
`timescale 1ns / 1ps

module cnmf_front
  import cnmf_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  input  logic                   pix_valid_i,
  input  logic [PixW-1:0]        pix_i,
  output logic                   pix_ready_o,
  input  logic                   q_full_i,
  output logic                   push_o,
  output logic [$bits(item_flags_t) + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + PixW - 1:0]
                                 item_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [WW-1:0] WReset = WW'((DimReset > MAX_WIDTH) ? MAX_WIDTH : DimReset);
  localparam logic [HW-1:0] HReset = HW'((DimReset > MAX_HEIGHT) ? MAX_HEIGHT : DimReset);

  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  item_flags_t   flags;

  function automatic logic [WW-1:0] clamp_w(input logic [FwCfgW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > 32'(MAX_WIDTH)) begin
      t = 32'(MAX_WIDTH);
    end
    return WW'(t);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [FhCfgW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > 32'(MAX_HEIGHT)) begin
      t = 32'(MAX_HEIGHT);
    end
    return HW'(t);
  endfunction

  assign pix_ready_o = !q_full_i;
  assign push_o      = pix_valid_i && pix_ready_o;

  // Classify the current frame position
  always_comb begin
    flags.up1      = (row_q != '0);
    flags.up2      = (row_q > RW'(1));
    flags.left1    = (col_q != '0);
    flags.left2    = (col_q > CW'(1));
    flags.right    = ((WW'(col_q) + WW'(1)) < w_q);
    flags.last_row = (HW'(row_q) == (h_q - HW'(1)));
    flags.last_col = (WW'(col_q) == (w_q - WW'(1)));
  end

  assign item_o = {flags, row_q, col_q, pix_i};

  // Frame size registers and raster position; any register write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= WReset;
      h_q   <= HReset;
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameWidth: begin
          w_q   <= clamp_w(cfg_data_i[FwCfgW-1:0]);
          col_q <= '0;
          row_q <= '0;
        end
        CfgFrameHeight: begin
          h_q   <= clamp_h(cfg_data_i[FhCfgW-1:0]);
          col_q <= '0;
          row_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (push_o) begin
      if (flags.last_col) begin
        col_q <= '0;
        row_q <= flags.last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

### src/cnmf_back.sv
// Back of the filter: line buffer reads, neighbour sums, result sequencing and
// the divide-by-count multiply into the output register. Depends on cnmf_pkg.
`timescale 1ns / 1ps

module cnmf_back
  import cnmf_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  logic [$bits(item_flags_t) + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + PixW - 1:0]
                              head_item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DataOutW-1:0] out_data_o,
  output logic                out_last_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(2 * MAX_WIDTH);
  localparam int XW    = SumW + 8;
  localparam int ProdW = XW + RecipW;
  localparam int PadW  = DataOutW - RowOutW - ColOutW - MeanW;

  // Result slots of one item, in emission order
  localparam logic [1:0] CandUp   = 2'd0;  // (r-1, c)
  localparam logic [1:0] CandLeft = 2'd1;  // (r, c-1), last row
  localparam logic [1:0] CandLast = 2'd2;  // (r, c), final pixel

  // Head of queue
  item_flags_t   hf;
  logic [RW-1:0] hr;
  logic [CW-1:0] hc;
  logic [PixW-1:0] hp;
  logic [CW-1:0] col_right;

  // Line buffers, one row per parity
  logic [PixW-1:0] mem [2 * MAX_WIDTH];
  logic [PixW-1:0] rd_a_q, rd_b_q;

  // Compute stage
  logic            cv_q;
  item_flags_t     cf_q;
  logic [RW-1:0]   cr_q;
  logic [CW-1:0]   cc_q;
  logic [PixW-1:0] cp_q;
  logic [PixW-1:0] win_l_q, win_c_q;
  logic [PixW-1:0] rec0_q, rec1_q;
  logic            pre_done_q;

  // Result slots
  logic [2:0]      cvld_q;
  logic [2:0]      cvld_new;
  logic [SumW-1:0] cand_sum_q [3];
  logic [CntW-1:0] cand_n_q [3];
  logic [SumW-1:0] sum_new [3];
  logic [CntW-1:0] n_new [3];
  logic [RW-1:0]   er_q;
  logic [CW-1:0]   ec_q;

  // Output register
  logic                m_valid_q;
  logic [DataOutW-1:0] m_data_q;
  logic                m_last_q;

  logic do_pre, do_issue, cmp_done, cand_free, out_free, emit;
  logic [1:0]      sel;
  logic [SumW-1:0] e_sum;
  logic [CntW-1:0] e_n;
  logic [RW-1:0]   e_row;
  logic [CW-1:0]   e_col;
  logic [XW-1:0]   e_x;
  logic [ProdW-1:0] e_prod;
  logic [31:0]     row_ext, col_ext;

  function automatic logic [AW-1:0] addr_of(input logic par, input logic [CW-1:0] col);
    return par ? (AW'(MAX_WIDTH) + AW'(col)) : AW'(col);
  endfunction

  assign {hf, hr, hc, hp} = head_item_i;
  assign col_right = hf.right ? (hc + CW'(1)) : hc;

  // Issue control: the first column of a row fetches the pixel above first,
  // once all earlier writes have landed
  assign out_free  = !m_valid_q || out_ready_i;
  assign emit      = out_free && (cvld_q != '0);
  assign cand_free = (cvld_q == '0) || (emit && ((cvld_q & (cvld_q - 3'd1)) == '0));
  assign cmp_done  = cv_q && cand_free;
  assign do_pre    = head_valid_i && !hf.left1 && !pre_done_q && !cv_q;
  assign do_issue  = head_valid_i && (hf.left1 || pre_done_q) && (!cv_q || cmp_done);
  assign pop_o     = do_issue;

  // Line buffer ports: two registered reads, one write
  always_ff @(posedge clk_i) begin
    if (do_pre) begin
      rd_a_q <= mem[addr_of(~hr[0], '0)];
    end else if (do_issue) begin
      rd_a_q <= mem[addr_of(~hr[0], col_right)];
    end
    if (do_issue) begin
      rd_b_q <= mem[addr_of(hr[0], hc)];
    end
    if (cmp_done) begin
      mem[addr_of(cr_q[0], cc_q)] <= cp_q;
    end
  end

  // Neighbour sums and counts of the item in the compute stage
  always_comb begin
    sum_new[CandUp] = SumW'(win_c_q) + SumW'(cp_q)
                    + (cf_q.up2   ? SumW'(rd_b_q)  : '0)
                    + (cf_q.left1 ? SumW'(win_l_q) : '0)
                    + (cf_q.right ? SumW'(rd_a_q)  : '0);
    n_new[CandUp]   = CntW'(2) + CntW'(cf_q.up2) + CntW'(cf_q.left1) + CntW'(cf_q.right);
    sum_new[CandLeft] = SumW'(rec0_q) + SumW'(cp_q)
                      + (cf_q.up1   ? SumW'(win_l_q) : '0)
                      + (cf_q.left2 ? SumW'(rec1_q)  : '0);
    n_new[CandLeft]   = CntW'(2) + CntW'(cf_q.up1) + CntW'(cf_q.left2);
    sum_new[CandLast] = SumW'(cp_q)
                      + (cf_q.up1   ? SumW'(win_c_q) : '0)
                      + (cf_q.left1 ? SumW'(rec0_q)  : '0);
    n_new[CandLast]   = CntW'(1) + CntW'(cf_q.up1) + CntW'(cf_q.left1);
    cvld_new[CandUp]   = cf_q.up1;
    cvld_new[CandLeft] = cf_q.last_row && cf_q.left1;
    cvld_new[CandLast] = cf_q.last_row && cf_q.last_col;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q       <= 1'b0;
      pre_done_q <= 1'b0;
      cvld_q     <= '0;
      m_valid_q  <= 1'b0;
      rec0_q     <= '0;
      rec1_q     <= '0;
    end else begin
      if (do_pre) begin
        pre_done_q <= 1'b1;
      end else if (do_issue) begin
        pre_done_q <= 1'b0;
      end
      if (do_issue) begin
        cv_q <= 1'b1;
      end else if (cmp_done) begin
        cv_q <= 1'b0;
      end
      if (cmp_done) begin
        cvld_q <= cvld_new;
        rec1_q <= rec0_q;
        rec0_q <= cp_q;
      end else if (emit) begin
        cvld_q[sel] <= 1'b0;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Compute stage payload and the window over the row above
  always_ff @(posedge clk_i) begin
    if (do_issue) begin
      cf_q <= hf;
      cr_q <= hr;
      cc_q <= hc;
      cp_q <= hp;
      if (!hf.left1) begin
        win_c_q <= rd_a_q;
      end
    end
    if (cmp_done) begin
      win_l_q  <= win_c_q;
      win_c_q  <= rd_a_q;
      er_q     <= cr_q;
      ec_q     <= cc_q;
      cand_sum_q <= sum_new;
      cand_n_q   <= n_new;
    end
  end

  // Pick the earliest pending result
  always_comb begin
    if (cvld_q[CandUp]) begin
      sel = CandUp;
    end else if (cvld_q[CandLeft]) begin
      sel = CandLeft;
    end else begin
      sel = CandLast;
    end
  end

  always_comb begin
    e_sum = cand_sum_q[sel];
    e_n   = cand_n_q[sel];
    case (sel)
      CandUp: begin
        e_row = er_q - RW'(1);
        e_col = ec_q;
      end
      CandLeft: begin
        e_row = er_q;
        e_col = ec_q - CW'(1);
      end
      default: begin
        e_row = er_q;
        e_col = ec_q;
      end
    endcase
    // Rounded 8.8 mean: (sum*256 + n/2) / n through a reciprocal multiply
    e_x     = {e_sum, 8'b0} + XW'(e_n >> 1);
    e_prod  = ProdW'(e_x) * ProdW'(mean_recip(e_n));
    row_ext = 32'(e_row);
    col_ext = 32'(e_col);
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {PadW'(0), e_prod[MeanShift +: MeanW], col_ext[ColOutW-1:0],
                   row_ext[RowOutW-1:0]};
      m_last_q <= (sel == CandLast);
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_data_q;
  assign out_last_o  = m_last_q;

endmodule

### src/cross_neighbour_mean_filter.sv
// Five-point cross mean filter over a streamed raster frame.
// Instantiates cnmf_front, cnmf_queue and cnmf_back; depends on cnmf_pkg.
//
// Usage:
//   s_axis carries one 8-bit pixel per transaction in raster order; the frame
//   position is tracked inside. m_axis carries one filtered pixel per
//   transaction: row, column and the 8.8 rounded mean of the pixel and its
//   in-frame up, down, left and right neighbours. tlast marks the final result
//   of a frame. The cfg channel writes frame_width (index 0) or frame_height
//   (index 1); cfg_ready_o stays high and a write restarts the frame: write when idle.
// Path: a pixel passes through the queue, the compute stage, the result slots
//   and the output register; at the first column of a row it first waits for the
//   back to drain and then fetches the pixel above from the line buffer.
// Throughput: one pixel per cycle inside a row above the last while m_axis is ready;
//   the last row makes up to three results per pixel on the one output register
//   and takes the next pixel as they drain; a row start waits for the back to drain.
// Reset: position returns to row 0, column 0, frame size 5 by 5 (clamped to
//   the maximum); line buffers are not cleared and need no sweep.
// Stall: the output register holds its result; the 4-entry queue keeps
//   taking pixels until full, then s_axis_tready drops.
`timescale 1ns / 1ps
`include "cross_neighbour_mean_filter_defines.svh"

module cross_neighbour_mean_filter
  import cnmf_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] pixel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DataOutW-1:0] m_axis_tdata,   // [11:0] row_index, [18:12] col_index,
                                              // [34:19] mean_value, [39:35] zero
  output logic                m_axis_tlast,   // frame_done
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int ItemW = $bits(item_flags_t) + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + PixW;

  logic             push;
  logic             pop;
  logic [ItemW-1:0] item_in;
  logic [ItemW-1:0] item_head;
  q_stat_t          q_stat;

  assign cfg_ready_o = 1'b1;

  cnmf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_i       (s_axis_tdata),
    .pix_ready_o (s_axis_tready),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .item_o      (item_in)
  );

  cnmf_queue #(
    .DW    (ItemW),
    .DEPTH (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (item_in),
    .pop_i  (pop),
    .data_o (item_head),
    .stat_o (q_stat)
  );

  cnmf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_stat.empty),
    .head_item_i  (item_head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // Queue handshake between front and back
  `CNMF_ASSERT_IMPL(a_no_push_full, push, !q_stat.full, "pixel queued while queue full")
  `CNMF_ASSERT_IMPL(a_no_pop_empty, pop, !q_stat.empty, "back popped an empty queue")
  `CNMF_ASSERT_NEXT(a_push_visible, push && q_stat.empty, !q_stat.empty, "queued pixel lost")

endmodule
